/* rtl/pidt_pkg.sv */
// Shared types and register map constants for the periodic interrupt down timer.
package pidt_pkg;

    // Item operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register indexes
    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_STATUS = 3'd1;
    localparam logic [2:0] REG_LOAD   = 3'd2;
    localparam logic [2:0] REG_CMP    = 3'd3;
    localparam logic [2:0] REG_CNT    = 3'd4;

    // Control word layout
    localparam int CTRL_BITS     = 26;
    localparam int CTRL_EN       = 0;
    localparam int CTRL_ENMOD    = 1;
    localparam int CTRL_OCIEN    = 2;
    localparam int CTRL_RLD      = 3;
    localparam int CTRL_PRESCALE = 4;
    localparam int CTRL_IOVW     = 17;
    localparam int CTRL_CLKSRC   = 24;

    // Status register bits
    localparam int STAT_OCIF = 0;

    // Counter commands for one accepted item (at most one is set)
    typedef struct packed {
        logic tick;       // prescaler advance, timer running
        logic restart;    // enable edge with restart-on-enable
        logic overwrite;  // load write with immediate overwrite
    } pidt_cmd_t;

endpackage

/* rtl/pidt_counter.sv */
// Prescaler and down counter with compare match detection.
module pidt_counter #(
    parameter int COUNT_BITS    = 32,
    parameter int PRESCALE_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pidt_pkg::pidt_cmd_t      cmd,
    input  logic [PRESCALE_BITS-1:0] divide,
    input  logic [COUNT_BITS-1:0]    restart_value,
    input  logic [COUNT_BITS-1:0]    load_value,
    input  logic [COUNT_BITS-1:0]    compare_value,
    output logic [COUNT_BITS-1:0]    count,
    output logic                     hit
);
    import pidt_pkg::*;

    logic [COUNT_BITS-1:0]    count_reg;
    logic [COUNT_BITS-1:0]    count_next;
    logic [PRESCALE_BITS-1:0] ps_reg;
    logic [PRESCALE_BITS-1:0] ps_next;
    logic                     step;

    // Next counter and prescaler state
    always_comb
    begin
        count_next = count_reg;
        ps_next    = ps_reg;
        step       = 1'b0;
        if (cmd.restart)
        begin
            count_next = restart_value;
            ps_next    = '0;
        end
        else if (cmd.overwrite)
        begin
            count_next = load_value;
        end
        else if (cmd.tick)
        begin
            if (ps_reg != divide)
            begin
                ps_next = ps_reg + 1'b1;
            end
            else
            begin
                ps_next = '0;
                step    = 1'b1;
                if (count_reg == '0)
                    count_next = restart_value;
                else
                    count_next = count_reg - 1'b1;
            end
        end
    end

    assign hit   = step && (count_next == compare_value);
    assign count = count_reg;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '1;
            ps_reg    <= '0;
        end
        else
        begin
            count_reg <= count_next;
            ps_reg    <= ps_next;
        end
    end

endmodule

/* rtl/periodic_interrupt_down_timer.sv */
// Top level of the periodic interrupt down timer: register file, counter, result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | input     | in_valid / in_ready | op, reg_index, write_data
//  out     | output    | out_valid/out_ready | read_data, irq_pending
//
// One item per cycle while in_ready holds: a tick, write or read is applied to the
// timer state at the transfer edge, its result is registered at that same edge and
// offered on out_valid from the next cycle on.
// in_ready is high whenever the output register is empty or drains this cycle,
// so a stalled consumer holds off input only while a result waits.
// Reset: control 0, status 0, load all ones, compare 0, counter all ones,
// prescaler 0; no result pending.
module periodic_interrupt_down_timer #(
    parameter int COUNT_BITS    = 32,
    parameter int PRESCALE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [2:0]  reg_index,
    input  logic [31:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] read_data,
    output logic        irq_pending
);
    import pidt_pkg::*;

    logic [CTRL_BITS-1:0]  ctrl_reg;
    logic [CTRL_BITS-1:0]  ctrl_next;
    logic                  flag_reg;
    logic                  flag_next;
    logic [COUNT_BITS-1:0] load_reg;
    logic [COUNT_BITS-1:0] load_next;
    logic [COUNT_BITS-1:0] cmp_reg;
    logic [COUNT_BITS-1:0] cmp_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [31:0]           rdata_reg;
    logic [31:0]           rdata_next;
    logic                  irq_reg;
    logic                  irq_next;

    logic                  in_fire;
    logic                  is_write;
    logic                  running;
    logic [COUNT_BITS-1:0] count;
    logic                  hit;
    logic [COUNT_BITS-1:0] restart_value;
    pidt_cmd_t             cmd;

    assign in_fire  = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign is_write = in_fire && (op == OP_WRITE);
    assign running  = ctrl_reg[CTRL_EN] && (ctrl_reg[CTRL_CLKSRC +: 2] != 2'b00);

    // Register writes
    always_comb
    begin
        ctrl_next = ctrl_reg;
        load_next = load_reg;
        cmp_next  = cmp_reg;
        if (is_write)
        begin
            unique case (reg_index)
                REG_CTRL: ctrl_next = write_data[CTRL_BITS-1:0];
                REG_LOAD: load_next = write_data[COUNT_BITS-1:0];
                REG_CMP:  cmp_next  = write_data[COUNT_BITS-1:0];
                default:  ;
            endcase
        end
    end

    // Counter commands
    always_comb
    begin
        cmd.tick      = in_fire && (op == OP_TICK) && running;
        cmd.restart   = is_write && (reg_index == REG_CTRL) && !ctrl_reg[CTRL_EN]
                        && write_data[CTRL_EN] && write_data[CTRL_ENMOD];
        cmd.overwrite = is_write && (reg_index == REG_LOAD) && ctrl_reg[CTRL_IOVW];
    end

    assign restart_value = ctrl_next[CTRL_RLD] ? load_reg : '1;

    pidt_counter #(
        .COUNT_BITS    (COUNT_BITS),
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_counter (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .divide        (ctrl_reg[CTRL_PRESCALE +: PRESCALE_BITS]),
        .restart_value (restart_value),
        .load_value    (load_next),
        .compare_value (cmp_reg),
        .count         (count),
        .hit           (hit)
    );

    // Status flag: set by a compare match, cleared by writing 1
    always_comb
    begin
        flag_next = flag_reg;
        if (is_write && (reg_index == REG_STATUS) && write_data[STAT_OCIF])
            flag_next = 1'b0;
        if (hit)
            flag_next = 1'b1;
    end

    // Read mux
    always_comb
    begin
        rdata_next = '0;
        if (op == OP_READ)
        begin
            unique case (reg_index)
                REG_CTRL:   rdata_next = 32'(ctrl_reg);
                REG_STATUS: rdata_next = 32'(flag_reg);
                REG_LOAD:   rdata_next = 32'(load_reg);
                REG_CMP:    rdata_next = 32'(cmp_reg);
                REG_CNT:    rdata_next = 32'(count);
                default:    rdata_next = '0;
            endcase
        end
    end

    assign irq_next       = flag_next && ctrl_next[CTRL_OCIEN];
    assign out_valid_next = in_fire || (out_valid_reg && !out_ready);

    // Timer state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg      <= '0;
            flag_reg      <= 1'b0;
            load_reg      <= '1;
            cmp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg      <= ctrl_next;
            flag_reg      <= flag_next;
            load_reg      <= load_next;
            cmp_reg       <= cmp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = rdata_reg;
    assign irq_pending = irq_reg;

`ifndef NO_ASSERTIONS
    // Result interrupt matches the state left by the item
    a_irq_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> irq_reg == (flag_reg && ctrl_reg[CTRL_OCIEN]))
        else $error("irq_pending disagrees with status and enable");

    // Ticks and writes return zero data
    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (op != OP_READ) |=> rdata_reg == '0)
        else $error("non-read item returned data");

    // Counter register is read only
    a_cnt_ro: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (op == OP_WRITE) && (reg_index == REG_CNT) |=> $stable(count))
        else $error("counter changed on counter write");

    // Counter only moves while running or on a control or load write
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(count) && $stable(flag_reg))
        else $error("timer state moved without a transfer");
`endif

endmodule
